FILE: design/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and constants of the nor flash array model
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_pkg;

    // default geometry, both powers of two
    localparam int unsigned ARRAY_BYTES_DEF  = 65536;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;

    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic [23:0] OFFSET_MAX  = 24'hFFFFFF;

    typedef enum logic [2:0] {
        CMD_OPEN         = 3'd0,
        CMD_CLOSE        = 3'd1,
        CMD_FULL_ERASE   = 3'd2,
        CMD_WRITE        = 3'd3,
        CMD_READ         = 3'd4,
        CMD_SECTOR_ERASE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_OPEN = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_ERASE,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;       // take the input transaction
        logic access_done;  // finish a byte read or write
        logic erase_step;   // erase one byte of the current range
        logic out_load;     // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_access;    // input item needs a memory access
        logic go_erase;     // input item starts an erase walk
        logic erase_last;   // current erase byte is the final one
        logic out_free;     // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// sequencing state machine: accept, byte access, erase walk, response
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire nfa_pkg::t_dp_stat i_stat,
    output      nfa_pkg::t_dp_cmd  o_cmd
);

    nfa_pkg::t_state r_state;
    nfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            nfa_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.go_access) begin
                        n_state = nfa_pkg::S_ACCESS;
                    end else if (i_stat.go_erase) begin
                        n_state = nfa_pkg::S_ERASE;
                    end else begin
                        n_state = nfa_pkg::S_RESP;
                    end
                end
            end
            nfa_pkg::S_ACCESS: begin
                o_cmd.access_done = 1'b1;
                n_state           = nfa_pkg::S_RESP;
            end
            nfa_pkg::S_ERASE: begin
                o_cmd.erase_step = 1'b1;
                if (i_stat.erase_last) begin
                    n_state = nfa_pkg::S_RESP;
                end
            end
            nfa_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = nfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfa_pkg::S_IDLE;
            end
        endcase
    end

    // a byte access state is always followed by the response state
    a_access_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfa_pkg::S_ACCESS) |=> (r_state == nfa_pkg::S_RESP))
        else $error("byte access did not finish in one cycle");

    // an item with no memory work goes straight to the response
    a_simple_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfa_pkg::S_IDLE && i_valid && !i_stat.go_access && !i_stat.go_erase)
        |=> (r_state == nfa_pkg::S_RESP))
        else $error("simple command did not go to response");

endmodule

`default_nettype wire

FILE: design/nfa_dpath.sv
// ----------------------------------------------------------------------------
// nfa_dpath
// byte array, ready flag, transfer offset, range checks and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_dpath #(
    parameter int unsigned ARRAY_BYTES  = nfa_pkg::ARRAY_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [2:0]        i_command,
    input  wire logic [31:0]       i_start_address,
    input  wire logic [23:0]       i_transfer_length,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    input  wire logic              i_stall,
    input  wire nfa_pkg::t_dp_cmd  i_cmd,
    output      nfa_pkg::t_dp_stat o_stat,
    output      logic [7:0]        o_read_byte,
    output      logic [1:0]        o_status,
    output      logic              o_valid
);

    localparam int unsigned ADDR_W    = $clog2(ARRAY_BYTES);
    localparam logic [32:0] ARRAY_END = 33'(ARRAY_BYTES);
    localparam logic [32:0] SECT_SIZE = 33'(SECTOR_BYTES);
    localparam logic [32:0] SECT_MASK = ~(33'(SECTOR_BYTES) - 33'd1);

    logic [7:0]        r_mem [ARRAY_BYTES];
    logic [7:0]        r_mem_q;

    logic              r_ready;
    logic [23:0]       r_offset;
    logic              r_is_write;
    logic [7:0]        r_data;
    logic [ADDR_W-1:0] r_acc_addr;
    logic [ADDR_W-1:0] r_erase_addr;
    logic [ADDR_W-1:0] r_erase_last;
    logic [7:0]        r_res_byte;
    nfa_pkg::t_status  r_res_status;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    nfa_pkg::t_status  r_out_status;

    logic [32:0]       xfer_end;
    logic              xfer_bad;
    logic              off_past;
    logic [32:0]       sect_base;
    logic              sect_bad;
    logic [ADDR_W-1:0] acc_addr;
    nfa_pkg::t_status  chk_status;
    logic              chk_access;
    logic              chk_erase;
    logic [ADDR_W-1:0] chk_erase_base;
    logic [ADDR_W-1:0] chk_erase_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    // checks on the item at the input
    assign xfer_end  = {1'b0, i_start_address} + {9'd0, i_transfer_length};
    assign xfer_bad  = xfer_end > ARRAY_END;
    assign off_past  = r_offset >= i_transfer_length;
    assign sect_base = {1'b0, i_start_address} & SECT_MASK;
    assign sect_bad  = (sect_base + SECT_SIZE) > ARRAY_END;
    assign acc_addr  = i_start_address[ADDR_W-1:0] + r_offset[ADDR_W-1:0];

    always_comb begin
        chk_status     = nfa_pkg::ST_OK;
        chk_access     = 1'b0;
        chk_erase      = 1'b0;
        chk_erase_base = '0;
        chk_erase_last = ADDR_W'(ARRAY_BYTES - 1);
        case (i_command)
            nfa_pkg::CMD_OPEN: begin
                chk_erase = 1'b1;
            end
            nfa_pkg::CMD_CLOSE: begin
                if (!r_ready) begin
                    chk_status = nfa_pkg::ST_NOT_OPEN;
                end
            end
            nfa_pkg::CMD_FULL_ERASE: begin
                if (!r_ready) begin
                    chk_status = nfa_pkg::ST_NOT_OPEN;
                end else begin
                    chk_erase = 1'b1;
                end
            end
            nfa_pkg::CMD_WRITE, nfa_pkg::CMD_READ: begin
                if (!r_ready) begin
                    chk_status = nfa_pkg::ST_NOT_OPEN;
                end else if (xfer_bad) begin
                    chk_status = nfa_pkg::ST_RANGE;
                end else if (!off_past) begin
                    chk_access = 1'b1;
                end
            end
            nfa_pkg::CMD_SECTOR_ERASE: begin
                chk_erase_base = ADDR_W'(sect_base);
                chk_erase_last = ADDR_W'(sect_base + SECT_SIZE - 33'd1);
                if (!r_ready) begin
                    chk_status = nfa_pkg::ST_NOT_OPEN;
                end else if (sect_bad) begin
                    chk_status = nfa_pkg::ST_RANGE;
                end else begin
                    chk_erase = 1'b1;
                end
            end
            default: begin
                chk_status = nfa_pkg::ST_OK;
            end
        endcase
    end

    assign o_stat.go_access  = chk_access;
    assign o_stat.go_erase   = chk_erase;
    assign o_stat.erase_last = (r_erase_addr == r_erase_last);
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    // single write port: erase walk or read-modify-write of a program
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_erase_addr;
        mem_wdata = nfa_pkg::ERASED_BYTE;
        if (i_cmd.erase_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.access_done && r_is_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_acc_addr;
            mem_wdata = r_mem_q & r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_mem_q <= r_mem[acc_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_command == nfa_pkg::CMD_OPEN) begin
                    r_ready <= 1'b1;
                end else if (i_command == nfa_pkg::CMD_CLOSE) begin
                    r_ready <= 1'b0;
                end
                if (i_command inside {nfa_pkg::CMD_WRITE, nfa_pkg::CMD_READ}) begin
                    if (i_last_byte) begin
                        r_offset <= '0;
                    end else if (r_offset != nfa_pkg::OFFSET_MAX) begin
                        r_offset <= r_offset + 24'd1;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_write   <= (i_command == nfa_pkg::CMD_WRITE);
            r_data       <= i_data_byte;
            r_acc_addr   <= acc_addr;
            r_erase_addr <= chk_erase_base;
            r_erase_last <= chk_erase_last;
            r_res_byte   <= 8'd0;
            r_res_status <= chk_status;
        end else begin
            if (i_cmd.erase_step) begin
                r_erase_addr <= r_erase_addr + ADDR_W'(1);
            end
            if (i_cmd.access_done && !r_is_write) begin
                r_res_byte <= r_mem_q;
            end
        end
        if (i_cmd.out_load) begin
            r_out_byte   <= r_res_byte;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_out_byte;
    assign o_status    = r_out_status;

    // the array becomes ready only through an open
    a_ready_by_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_ready && !$past(r_ready))
        |-> $past(i_cmd.accept && i_command == nfa_pkg::CMD_OPEN))
        else $error("ready set without open");

    // the offset moves only on an accepted read or write item
    a_offset_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_offset != $past(r_offset))
        |-> $past(i_cmd.accept
                  && (i_command == nfa_pkg::CMD_WRITE || i_command == nfa_pkg::CMD_READ)))
        else $error("offset changed outside a transfer item");

    // a byte access completes right after its item was accepted
    a_access_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.access_done |-> $past(i_cmd.accept && chk_access))
        else $error("access without an accepted item");

endmodule

`default_nettype wire

FILE: design/nor_flash_array_model_top.sv
// ----------------------------------------------------------------------------
// nor_flash_array_model_top
// nor flash byte array with open, close, erase, byte program and byte read
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with command, start address, transfer
//   length, data byte and last byte flag; one transaction per command or
//   per byte of a read or write transfer
//   output channel: o_valid / i_stall with read byte and status; exactly one
//   result transaction per input transaction, in order
//   states per item, set by the single-port byte array and the sequencer:
//     close, unused codes, failing commands, bytes past the length: idle, response
//     byte read or byte write (read, then program write-back): idle, access, response
//     open and full erase walk the whole array, sector erase one sector, in the
//     erase state between idle and response, one byte erased per cycle
//   reset clears the ready flag, the transfer offset and the output valid;
//   the array content is undefined until an open erases it, so no clearing
//   pass runs after reset
//   a stalled result sits in the output register; the block accepts the next
//   transaction meanwhile and holds its own result until the register frees
//   both geometry parameters, unchecked by the block, must be powers of two
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_array_model_top #(
    parameter int unsigned ARRAY_BYTES  = nfa_pkg::ARRAY_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = nfa_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transactions
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_start_address,
    input  wire logic [23:0] i_transfer_length,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // result transactions
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [7:0]  o_read_byte,
    output      logic [1:0]  o_status
);

    nfa_pkg::t_dp_cmd  dp_cmd;   // sequencer commands
    nfa_pkg::t_dp_stat dp_stat;  // checks and walk status back

    // state machine: idle, byte access, erase walk, response
    nfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // byte array, flags, range checks and output register
    nfa_dpath #(
        .ARRAY_BYTES  (ARRAY_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_command         (i_command),
        .i_start_address   (i_start_address),
        .i_transfer_length (i_transfer_length),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_stall           (i_stall),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .o_read_byte       (o_read_byte),
        .o_status          (o_status),
        .o_valid           (o_valid)
    );

endmodule

`default_nettype wire

FILE: tb/nor_flash_array_model_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nor_flash_array_model_top_test
// self-checking testbench of the nor flash byte array
// ----------------------------------------------------------------------------
// a behavioral copy of the flash array (store, ready flag, transfer offset)
// predicts one response per accepted input transaction; a checker compares
// every accepted response field by field against the oldest prediction
// directed tests cover the closed state, bit-clearing programs, range
// failures, offset overrun and reopen; random phases then mix well-formed
// byte transfers with broken transfers, sector erases and noise under
// several sender idle and receiver stall patterns
// ----------------------------------------------------------------------------

module nor_flash_array_model_top_test;

    // geometry used by the instance and by the prediction
    localparam int unsigned FLASH_BYTES  = nfa_pkg::ARRAY_BYTES_DEF;
    localparam int unsigned SECTOR_SIZE  = nfa_pkg::SECTOR_BYTES_DEF;

    // command codes the block decodes as no-ops
    localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7  = 3'd7;

    // an open walks the whole array, so allow several of those per stretch
    localparam int          IDLE_LIMIT   = 200000;
    localparam int          HOLDOFF_LEN  = 400;

    typedef struct {
        logic [7:0]       read_byte;
        nfa_pkg::t_status status;
    } t_flash_response;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [31:0] i_start_address = '0;
    logic [23:0] i_transfer_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_status;

    // predicted flash contents and control state
    logic [7:0]  flash_bytes [FLASH_BYTES];
    logic        flash_open = 1'b0;
    logic [23:0] xfer_offset = '0;

    // responses predicted but not yet seen
    t_flash_response pending_responses [$];

    // traffic shaping knobs, percent per cycle, and a receiver hold-off length
    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    int holdoff_cycles = 0;

    int mismatch_count = 0;
    int items_sent = 0;
    int idle_count = 0;

    nor_flash_array_model_top #(
        .ARRAY_BYTES  (FLASH_BYTES),
        .SECTOR_BYTES (SECTOR_SIZE)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_start_address   (i_start_address),
        .i_transfer_length (i_transfer_length),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_byte       (o_read_byte),
        .o_status          (o_status)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void erase_bytes(input int unsigned base, input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            flash_bytes[base + i] = nfa_pkg::ERASED_BYTE;
        end
    endfunction

    // advance the flash state by one transaction and queue its response
    function automatic void predict_flash_response(
        input logic [2:0]  cmd,
        input logic [31:0] addr,
        input logic [23:0] len,
        input logic [7:0]  data,
        input logic        last
    );
        t_flash_response resp;
        logic [63:0]     span_end;
        logic [63:0]     sector_base;
        int unsigned     idx;
        resp.read_byte = 8'h00;
        resp.status    = nfa_pkg::ST_OK;
        // range checks run in 64 bits so a 32 bit start never wraps
        span_end    = {32'd0, addr} + {40'd0, len};
        sector_base = {32'd0, addr} & ~64'(SECTOR_SIZE - 1);
        case (cmd)
            nfa_pkg::CMD_OPEN: begin
                erase_bytes(0, FLASH_BYTES);
                flash_open = 1'b1;
            end
            nfa_pkg::CMD_CLOSE: begin
                if (!flash_open) resp.status = nfa_pkg::ST_NOT_OPEN;
                else flash_open = 1'b0;
            end
            nfa_pkg::CMD_FULL_ERASE: begin
                if (!flash_open) resp.status = nfa_pkg::ST_NOT_OPEN;
                else erase_bytes(0, FLASH_BYTES);
            end
            nfa_pkg::CMD_WRITE, nfa_pkg::CMD_READ: begin
                if (!flash_open) begin
                    resp.status = nfa_pkg::ST_NOT_OPEN;
                end else if (span_end > 64'(FLASH_BYTES)) begin
                    resp.status = nfa_pkg::ST_RANGE;
                end else if (xfer_offset < len) begin
                    // offset at or past the length means no access at all
                    idx = addr + {8'd0, xfer_offset};
                    if (cmd == nfa_pkg::CMD_WRITE) flash_bytes[idx] = flash_bytes[idx] & data;
                    else resp.read_byte = flash_bytes[idx];
                end
                // offset moves on every byte transaction, failing ones too
                if (last) xfer_offset = '0;
                else if (xfer_offset != nfa_pkg::OFFSET_MAX) xfer_offset = xfer_offset + 24'd1;
            end
            nfa_pkg::CMD_SECTOR_ERASE: begin
                if (!flash_open) resp.status = nfa_pkg::ST_NOT_OPEN;
                else if (sector_base + 64'(SECTOR_SIZE) > 64'(FLASH_BYTES))
                    resp.status = nfa_pkg::ST_RANGE;
                else erase_bytes(32'(sector_base), SECTOR_SIZE);
            end
            default: ;
        endcase
        pending_responses.push_back(resp);
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // outputs are sampled at the edge, before the edge's own updates land
    always @(posedge i_clk) begin
        t_flash_response want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no transaction waiting");
            end else begin
                want = pending_responses.pop_front();
                if (o_read_byte !== want.read_byte)
                    report_mismatch($sformatf("read byte %02h, predicted %02h",
                                              o_read_byte, want.read_byte));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              o_status, want.status));
            end
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_cycles > 0) begin
            i_stall <= 1'b1;
            holdoff_cycles = holdoff_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_count <= 0;
        end else if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // offer one transaction and hold it until the block takes it; the
    // prediction runs at the accepting edge, then an optional idle gap
    task automatic offer_item(
        input logic [2:0]  cmd,
        input logic [31:0] addr,
        input logic [23:0] len,
        input logic [7:0]  data,
        input logic        last
    );
        int gap;
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_start_address   <= addr;
        i_transfer_length <= len;
        i_data_byte       <= data;
        i_last_byte       <= last;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_flash_response(cmd, addr, len, data, last);
        items_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        // valid only drops when a gap follows, so it never toggles in one step
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // n byte transactions of one transfer, random data, last flag optional
    task automatic send_transfer(
        input logic [2:0]  cmd,
        input logic [31:0] addr,
        input logic [23:0] len,
        input int          n_items,
        input logic        close_it
    );
        for (int k = 0; k < n_items; k++) begin
            offer_item(cmd, addr, len, 8'($urandom), close_it && (k == n_items - 1));
        end
    endtask

    // sender stops until every predicted response has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_responses.size() != 0);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 0;
        if (r < 15) return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    // addresses cluster in a few regions so reads land on programmed bytes
    function automatic logic [31:0] pick_hot_address();
        case ($urandom_range(3))
            0: return 32'($urandom_range(0, 511));
            1: return 32'h7000 + 32'($urandom_range(0, 511));
            2: return 32'hFE00 + 32'($urandom_range(0, 511));
            default: return 32'($urandom_range(0, FLASH_BYTES - 1));
        endcase
    endfunction

    // every command but open fails while closed, spare codes pass as no-ops
    task automatic test_closed_commands();
        offer_item(nfa_pkg::CMD_CLOSE, 32'h0, 24'h0, 8'h00, 1'b1);
        offer_item(nfa_pkg::CMD_FULL_ERASE, 32'h0, 24'h0, 8'h00, 1'b1);
        // offset still advances on a failing byte
        offer_item(nfa_pkg::CMD_WRITE, 32'h0, 24'd4, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_READ, 32'h0, 24'd4, 8'hFF, 1'b1);
        offer_item(nfa_pkg::CMD_SECTOR_ERASE, 32'h0, 24'h0, 8'h00, 1'b0);
        offer_item(CMD_SPARE_6, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 1'b1);
        wait_drained();
    endtask

    // programs only clear bits; a short transfer walks the offset
    task automatic test_program_and_readback();
        offer_item(nfa_pkg::CMD_OPEN, 32'h0, 24'h0, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_WRITE, 32'h0, 24'd1, 8'hF0, 1'b1);
        offer_item(nfa_pkg::CMD_WRITE, 32'h0, 24'd1, 8'h3C, 1'b1);
        offer_item(nfa_pkg::CMD_READ, 32'h0, 24'd1, 8'h00, 1'b1);
        offer_item(nfa_pkg::CMD_WRITE, 32'h100, 24'd3, 8'h5A, 1'b0);
        offer_item(nfa_pkg::CMD_WRITE, 32'h100, 24'd3, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_WRITE, 32'h100, 24'd3, 8'hA5, 1'b1);
        send_transfer(nfa_pkg::CMD_READ, 32'h100, 24'd3, 3, 1'b1);
        wait_drained();
    endtask

    // out-of-range transfers and sectors, zero length and offset overrun
    task automatic test_range_and_offset();
        offer_item(nfa_pkg::CMD_WRITE, 32'hFFFF, 24'd2, 8'h00, 1'b1);
        offer_item(nfa_pkg::CMD_READ, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h00, 1'b1);
        // ends exactly at the array boundary with nothing to move
        offer_item(nfa_pkg::CMD_READ, 32'h1_0000, 24'd0, 8'h00, 1'b1);
        // third byte of a two byte transfer is past the length
        send_transfer(nfa_pkg::CMD_READ, 32'h0, 24'd2, 3, 1'b1);
        offer_item(nfa_pkg::CMD_SECTOR_ERASE, 32'hFFFF_F000, 24'h0, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_WRITE, 32'hFFFF, 24'd1, 8'h00, 1'b1);
        offer_item(nfa_pkg::CMD_SECTOR_ERASE, 32'hF123, 24'h0, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_READ, 32'hFFFF, 24'd1, 8'h00, 1'b1);
        offer_item(CMD_SPARE_7, 32'h0, 24'h0, 8'h00, 1'b0);
        wait_drained();
    endtask

    // close twice, then reopen and full erase
    task automatic test_close_and_reopen();
        offer_item(nfa_pkg::CMD_CLOSE, 32'h0, 24'h0, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_CLOSE, 32'h0, 24'h0, 8'h00, 1'b0);
        offer_item(nfa_pkg::CMD_OPEN, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 1'b1);
        offer_item(nfa_pkg::CMD_FULL_ERASE, 32'h0, 24'h0, 8'h00, 1'b0);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps pushing, so the block backs up
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        rx_stall_pct   = 0;
        holdoff_cycles = HOLDOFF_LEN;
        send_transfer(nfa_pkg::CMD_READ, 32'h0, 24'd32, 32, 1'b1);
        wait_drained();
    endtask

    // random traffic, one whole-array operation somewhere in each phase
    task automatic run_random_phase(input int n_items, input int send_pct, input int stall_pct);
        int          target;
        int          long_at;
        bit          long_done;
        int          r;
        int          len;
        int          n;
        logic [2:0]  op;
        logic [31:0] addr;
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
        target    = items_sent + n_items;
        long_at   = items_sent + $urandom_range(n_items - 1);
        long_done = 1'b0;
        while (items_sent < target) begin
            if (!long_done && items_sent >= long_at) begin
                long_done = 1'b1;
                // these walk the whole array, keep them rare
                case ($urandom_range(2))
                    0: offer_item(nfa_pkg::CMD_OPEN, $urandom, 24'($urandom), 8'($urandom),
                                  1'($urandom));
                    1: offer_item(nfa_pkg::CMD_FULL_ERASE, $urandom, 24'($urandom),
                                  8'($urandom), 1'($urandom));
                    default: begin
                        // closed episode: one to three random commands while closed, then reopen
                        offer_item(nfa_pkg::CMD_CLOSE, $urandom, 24'($urandom), 8'($urandom),
                                   1'($urandom));
                        repeat ($urandom_range(1, 3))
                            offer_item(3'($urandom_range(1, 7)), pick_hot_address(),
                                       24'(pick_length()), 8'($urandom), 1'($urandom));
                        offer_item(nfa_pkg::CMD_OPEN, $urandom, 24'($urandom), 8'($urandom),
                                   1'($urandom));
                    end
                endcase
            end
            r  = $urandom_range(99);
            op = $urandom_range(1) ? nfa_pkg::CMD_WRITE : nfa_pkg::CMD_READ;
            if (r < 68) begin
                // well-formed transfer
                len  = pick_length();
                addr = pick_hot_address();
                send_transfer(op, addr, 24'(len), (len == 0) ? 1 : len, 1'b1);
            end else if (r < 80) begin
                // cut short or overrun, sometimes without a last byte
                len  = pick_length();
                addr = pick_hot_address();
                n    = $urandom_range(1, len + 3);
                send_transfer(op, addr, 24'(len), n, $urandom_range(3) != 0);
            end else if (r < 83) begin
                addr = ($urandom_range(3) == 0) ? $urandom : pick_hot_address();
                offer_item(nfa_pkg::CMD_SECTOR_ERASE, addr, 24'($urandom), 8'($urandom),
                           1'($urandom));
            end else if (r < 96) begin
                // noise across byte, sector and spare codes with any fields
                offer_item(3'($urandom_range(3, 7)), $urandom, 24'($urandom), 8'($urandom),
                           1'($urandom));
            end else begin
                len = $urandom_range(FLASH_BYTES + 1, 24'hFF_FFFF);
                send_transfer(op, $urandom, 24'(len), $urandom_range(1, 3), 1'b1);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        test_closed_commands();
        test_program_and_readback();
        test_range_and_offset();
        test_close_and_reopen();
        test_output_holdoff();

        // random part under each idle pattern
        run_random_phase(260, 0, 0);
        run_random_phase(260, 83, 0);
        run_random_phase(260, 0, 83);
        run_random_phase(260, 36, 36);

        // let any stray response show up before the verdict
        rx_stall_pct = 0;
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: nor_flash_array_model_top.f
design/nfa_pkg.sv
design/nfa_ctrl.sv
design/nfa_dpath.sv
design/nor_flash_array_model_top.sv
tb/nor_flash_array_model_top_test.sv
